/* hw/rtl/ctls_pkg.sv */
// Package: shared types, constants and command codes for the contingency table link select block.
package ctls_pkg;

    localparam int ID_W      = 5;
    localparam int PCT_W     = 7;
    localparam int TOTAL_W   = 24;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

    localparam int MAX_CLUSTERS_DEF   = 32;
    localparam int COUNT_WIDTH_DEF    = 16;
    localparam int FIRST_REPORTED_DEF = 1;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FWD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REV   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BEST_ONLY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERCENT = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ID_W-1:0]  first_id;
        logic [ID_W-1:0]  second_id;
        logic [ID_W-1:0]  query_id;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]  linked_id;
        logic [PCT_W-1:0] link_percent;
        logic             link_valid;
        logic             last_link;
    } result_t;

endpackage

/* hw/rtl/contingency_table_link_select.sv */
// Top level: contingency table of two cluster labelings with link queries.
// Usage:
//   item channel (item_valid/item_stall/item) carries one command per transfer:
//   add pair, forward row query, reverse column query or clear table.
//   result channel (result_valid/result_stall/result) returns the links of a
//   query, the last one marked by last_link; an empty query returns a single
//   result with link_valid low. Add and clear return nothing.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes best_only and
//   min_percent; cfg_ready is always high. Write it only while idle.
// Timing: the block takes one item at a time and holds item_stall high while
//   it works. An add reads the count and writes it back incremented. A clear
//   sweeps all 2**(clog2(cluster count)+5) count memory entries, one a cycle,
//   1024 at the default size; the same sweep runs right after reset. A query
//   walks the scanned ids with one memory read each and, for a nonzero count,
//   one pass through the shared percentage divider (cut short when the row
//   total is zero or the quotient clamps) and one judge step, then a final
//   state hands off the end.
// Stall: while result_stall is high the held result stays put and the scan
//   waits for the result register before it produces the next link.
module contingency_table_link_select #(
    parameter int MAX_CLUSTERS   = ctls_pkg::MAX_CLUSTERS_DEF,
    parameter int COUNT_WIDTH    = ctls_pkg::COUNT_WIDTH_DEF,
    parameter int FIRST_REPORTED = ctls_pkg::FIRST_REPORTED_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  ctls_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output ctls_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ctls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ctls_pkg::PCT_W-1:0]       cfg_data
);

    localparam int NCL    = (MAX_CLUSTERS < 32) ? MAX_CLUSTERS : 32;
    localparam int ID_W   = ctls_pkg::ID_W;
    localparam int ROW_W  = $clog2(NCL);
    localparam int ADDR_W = ROW_W + ID_W;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam logic [ID_W:0]   NCL_ID  = (ID_W+1)'(NCL);
    localparam logic [ID_W-1:0] K_FIRST = ID_W'(FIRST_REPORTED);
    localparam logic [ID_W-1:0] K_LAST  = ID_W'(NCL - 1);
    localparam bit   SCAN_NONE = (FIRST_REPORTED >= NCL);
    localparam logic [ctls_pkg::TOTAL_W-1:0] TOTAL_SAT = '1;
    localparam logic [COUNT_WIDTH-1:0]       COUNT_SAT = '1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WR, S_SCAN_RD, S_SCAN_CNT, S_PCT, S_JUDGE, S_FINAL
    } state_t;

    // count memory
    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;

    logic [ctls_pkg::TOTAL_W-1:0] totals_reg [NCL];

    state_t                      state_reg;
    logic [ADDR_W-1:0]           clr_reg;
    logic                        fwd_reg;
    logic [ID_W-1:0]             q_reg;
    logic [ID_W-1:0]             a_reg;
    logic [ID_W-1:0]             b_reg;
    logic [ID_W-1:0]             k_reg;
    logic                        best_only_reg;
    logic [ctls_pkg::PCT_W-1:0]  min_pct_reg;
    logic                        found_reg;
    logic [ID_W-1:0]             best_id_reg;
    logic [ctls_pkg::PCT_W-1:0]  best_pct_reg;
    logic                        pend_reg;
    logic [ID_W-1:0]             pend_id_reg;
    logic [ctls_pkg::PCT_W-1:0]  pend_pct_reg;
    logic [ctls_pkg::PCT_W-1:0]  pct_reg;
    logic                        result_valid_reg;
    ctls_pkg::result_t           result_reg;

    logic                        item_take;
    logic                        out_free;
    logic                        res_load;
    logic [ID_W-1:0]             scan_row;
    logic [ID_W-1:0]             scan_col;
    logic                        pct_start;
    logic                        pct_done;
    logic [ctls_pkg::PCT_W-1:0]  pct_val;
    logic                        ids_ok;
    logic                        q_ok;

    assign item_take = item_valid && !item_stall;
    assign out_free  = !result_valid_reg || !result_stall;
    // Result register loads a new result this cycle
    assign res_load  = out_free && (((state_reg == S_JUDGE) && !best_only_reg
                                     && (pct_reg >= min_pct_reg) && pend_reg)
                                    || (state_reg == S_FINAL));
    assign scan_row  = fwd_reg ? q_reg : k_reg;
    assign scan_col  = fwd_reg ? k_reg : q_reg;
    assign pct_start = (state_reg == S_SCAN_CNT) && (rd_data_reg != '0);
    assign ids_ok    = ({1'b0, a_reg} < NCL_ID) && ({1'b0, b_reg} < NCL_ID);
    assign q_ok      = ({1'b0, item.query_id} < NCL_ID);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = '0;
        mem_raddr = {scan_row[ROW_W-1:0], scan_col};
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_ADD_WR)
        begin
            mem_we    = ids_ok && (rd_data_reg != COUNT_SAT);
            mem_waddr = {a_reg[ROW_W-1:0], b_reg};
            mem_wdata = rd_data_reg + COUNT_WIDTH'(1);
        end
        if (state_reg == S_ADD_RD)
        begin
            mem_raddr = {a_reg[ROW_W-1:0], b_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    ctls_pct_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_pct (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pct_start),
        .count (rd_data_reg),
        .total (totals_reg[scan_row[ROW_W-1:0]]),
        .done  (pct_done),
        .pct   (pct_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            fwd_reg          <= 1'b0;
            q_reg            <= '0;
            a_reg            <= '0;
            b_reg            <= '0;
            k_reg            <= '0;
            best_only_reg    <= 1'b1;
            min_pct_reg      <= '0;
            found_reg        <= 1'b0;
            best_id_reg      <= '0;
            best_pct_reg     <= '0;
            pend_reg         <= 1'b0;
            pend_id_reg      <= '0;
            pend_pct_reg     <= '0;
            pct_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            for (int i = 0; i < NCL; i++)
            begin
                totals_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    ctls_pkg::CFG_BEST_ONLY:   best_only_reg <= cfg_data[0];
                    ctls_pkg::CFG_MIN_PERCENT: min_pct_reg   <= cfg_data;
                    default:                   ;
                endcase
            end

            // Drop the held result once it is taken, unless a new one replaces it.
            if (result_valid_reg && !result_stall && !res_load)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (clr_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (item_take)
                    begin
                        a_reg     <= item.first_id;
                        b_reg     <= item.second_id;
                        q_reg     <= item.query_id;
                        fwd_reg   <= (item.command == ctls_pkg::CMD_FWD);
                        k_reg     <= K_FIRST;
                        found_reg <= 1'b0;
                        pend_reg  <= 1'b0;
                        unique case (item.command)
                            ctls_pkg::CMD_ADD:
                            begin
                                state_reg <= S_ADD_RD;
                            end
                            ctls_pkg::CMD_CLEAR:
                            begin
                                clr_reg   <= '0;
                                state_reg <= S_CLEAR;
                                for (int i = 0; i < NCL; i++)
                                begin
                                    totals_reg[i] <= '0;
                                end
                            end
                            default:
                            begin
                                state_reg <= (q_ok && !SCAN_NONE) ? S_SCAN_RD : S_FINAL;
                            end
                        endcase
                    end
                end
                S_ADD_RD:
                begin
                    state_reg <= S_ADD_WR;
                end
                S_ADD_WR:
                begin
                    // Count write happens in the memory block; bump the row total here.
                    if (ids_ok && (totals_reg[a_reg[ROW_W-1:0]] != TOTAL_SAT))
                    begin
                        totals_reg[a_reg[ROW_W-1:0]] <= totals_reg[a_reg[ROW_W-1:0]]
                                                        + ctls_pkg::TOTAL_W'(1);
                    end
                    state_reg <= S_IDLE;
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CNT;
                end
                S_SCAN_CNT:
                begin
                    if (rd_data_reg != '0)
                    begin
                        state_reg <= S_PCT;
                    end
                    else if (k_reg == K_LAST)
                    begin
                        state_reg <= S_FINAL;
                    end
                    else
                    begin
                        k_reg     <= k_reg + ID_W'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_PCT:
                begin
                    if (pct_done)
                    begin
                        pct_reg   <= pct_val;
                        state_reg <= S_JUDGE;
                    end
                end
                S_JUDGE:
                begin
                    logic advance;
                    advance = 1'b1;
                    if (best_only_reg)
                    begin
                        if (!found_reg || (pct_reg > best_pct_reg))
                        begin
                            found_reg    <= 1'b1;
                            best_id_reg  <= k_reg;
                            best_pct_reg <= pct_reg;
                        end
                    end
                    else if (pct_reg >= min_pct_reg)
                    begin
                        if (pend_reg && !out_free)
                        begin
                            // Hold until the result register frees.
                            advance = 1'b0;
                        end
                        else
                        begin
                            if (pend_reg)
                            begin
                                result_valid_reg      <= 1'b1;
                                result_reg.linked_id    <= pend_id_reg;
                                result_reg.link_percent <= pend_pct_reg;
                                result_reg.link_valid   <= 1'b1;
                                result_reg.last_link    <= 1'b0;
                            end
                            pend_reg     <= 1'b1;
                            pend_id_reg  <= k_reg;
                            pend_pct_reg <= pct_reg;
                        end
                    end
                    if (advance)
                    begin
                        if (k_reg == K_LAST)
                        begin
                            state_reg <= S_FINAL;
                        end
                        else
                        begin
                            k_reg     <= k_reg + ID_W'(1);
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_FINAL:
                begin
                    if (out_free)
                    begin
                        result_valid_reg     <= 1'b1;
                        result_reg.last_link <= 1'b1;
                        if (best_only_reg && found_reg)
                        begin
                            result_reg.linked_id    <= best_id_reg;
                            result_reg.link_percent <= best_pct_reg;
                            result_reg.link_valid   <= 1'b1;
                        end
                        else if (!best_only_reg && pend_reg)
                        begin
                            result_reg.linked_id    <= pend_id_reg;
                            result_reg.link_percent <= pend_pct_reg;
                            result_reg.link_valid   <= 1'b1;
                        end
                        else
                        begin
                            result_reg.linked_id    <= '0;
                            result_reg.link_percent <= '0;
                            result_reg.link_valid   <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.link_valid |-> result_reg.last_link)
        else $error("empty result without last_link");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> result_reg.link_percent <= ctls_pkg::PCT_MAX)
        else $error("link_percent above 100");

    a_done_in_pct: assert property (@(posedge clk) disable iff (!rst_n)
        pct_done |-> state_reg == S_PCT)
        else $error("percentage unit finished outside its wait state");

    a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
        pct_start |=> state_reg == S_PCT && !pct_start)
        else $error("percentage unit restarted");

endmodule

/* hw/rtl/ctls_pct_unit.sv */
// Iterative row percentage: floor(count*100/total), 0 for a zero total, clamped to 100, one quotient bit a cycle.
module ctls_pct_unit #(
    parameter int COUNT_WIDTH = ctls_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [COUNT_WIDTH-1:0]             count,
    input  logic [ctls_pkg::TOTAL_W-1:0]       total,
    output logic                               done,
    output logic [ctls_pkg::PCT_W-1:0]         pct
);

    localparam int NW = COUNT_WIDTH + 7;
    localparam int PW = (NW > ctls_pkg::TOTAL_W + 7) ? NW : ctls_pkg::TOTAL_W + 7;

    typedef enum logic [1:0] {P_IDLE, P_CHK, P_DIV} pstate_t;

    pstate_t                      state_reg;
    logic [PW-1:0]                rem_reg;
    logic [ctls_pkg::TOTAL_W-1:0] tot_reg;
    logic [2:0]                   bit_reg;
    logic [ctls_pkg::PCT_W-1:0]   quo_reg;
    logic                         done_reg;
    logic [ctls_pkg::PCT_W-1:0]   pct_reg;

    logic [PW-1:0]              cnt_ext;
    logic [PW-1:0]              num;
    logic [PW-1:0]              tot_ext;
    logic [PW-1:0]              div_sub;
    logic                       div_fit;
    logic [ctls_pkg::PCT_W-1:0] quo_next;

    always_comb
    begin
        cnt_ext  = PW'(count);
        num      = (cnt_ext << 6) + (cnt_ext << 5) + (cnt_ext << 2);
        tot_ext  = PW'(tot_reg);
        div_sub  = tot_ext << bit_reg;
        div_fit  = (rem_reg >= div_sub);
        quo_next = quo_reg;
        if (div_fit)
        begin
            quo_next[bit_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
            rem_reg   <= '0;
            tot_reg   <= '0;
            bit_reg   <= '0;
            quo_reg   <= '0;
            pct_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= num;
                        tot_reg   <= total;
                        state_reg <= P_CHK;
                    end
                end
                P_CHK:
                begin
                    // Zero total reads as zero; a quotient of 128 or more clamps.
                    if (tot_reg == '0)
                    begin
                        pct_reg   <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= P_IDLE;
                    end
                    else if (rem_reg >= (tot_ext << 7))
                    begin
                        pct_reg   <= ctls_pkg::PCT_MAX;
                        done_reg  <= 1'b1;
                        state_reg <= P_IDLE;
                    end
                    else
                    begin
                        bit_reg   <= 3'd6;
                        quo_reg   <= '0;
                        state_reg <= P_DIV;
                    end
                end
                P_DIV:
                begin
                    if (div_fit)
                    begin
                        rem_reg <= rem_reg - div_sub;
                    end
                    quo_reg <= quo_next;
                    if (bit_reg == 3'd0)
                    begin
                        pct_reg   <= (quo_next > ctls_pkg::PCT_MAX) ? ctls_pkg::PCT_MAX
                                                                     : quo_next;
                        done_reg  <= 1'b1;
                        state_reg <= P_IDLE;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 3'd1;
                    end
                end
                default:
                begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign pct  = pct_reg;

endmodule
